>>> hdl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
// Empty in synthesis; each use expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: always");
// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/bffa_pkg.sv
// Types and constants for the first-fit bitmap allocator.
// No dependencies; used by every other file of the block but assert_macros.svh.
package bffa_pkg;

	localparam int MAX_ENTRIES = 8192;
	localparam int CNT_W       = 14;
	localparam int WORD_W      = 32;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int WORD_CNT    = MAX_ENTRIES / WORD_W;
	localparam int ADDR_W      = $clog2(WORD_CNT);
	localparam int CHUNK_CNT   = WORD_CNT / WORD_W;
	localparam int CHUNK_IDX_W = $clog2(CHUNK_CNT);

	localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(MAX_ENTRIES);

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_FULL = 2'd1,
		STATUS_BAD  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_FREE,
		OP_REJECT
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [ADDR_W-1:0] word_idx;
		logic [BIT_W-1:0]  bit_idx;
		logic [CNT_W-1:0]  lim;
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_READ,
		BK_MODIFY,
		BK_FINISH
	} bk_state_t;

endpackage

>>> hdl/bffa_if.sv
// Request and response channel interfaces of the bitmap allocator.
// Depends on bffa_pkg for field widths.
interface bffa_req_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [bffa_pkg::CNT_W-1:0] entry_number;

	modport source (output valid, output cmd, output entry_number, input ready);
	modport sink   (input valid, input cmd, input entry_number, output ready);
endinterface

interface bffa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [bffa_pkg::CNT_W-1:0] granted_number;
	logic [1:0]                 status;
	logic [bffa_pkg::CNT_W-1:0] free_entries;

	modport source (output valid, output granted_number, output status,
		output free_entries, input ready);
	modport sink   (input valid, input granted_number, input status,
		input free_entries, output ready);
endinterface

>>> hdl/bffa_front.sv
// Front end: takes requests, checks free numbers against the limit and
// stages a classified operation for the queue. Depends on bffa_pkg, bffa_if.
module bffa_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bffa_pkg::CNT_W-1:0] entries_in_use,
	bffa_req_if.sink                   req,
	output logic                       push_valid,
	input  logic                       push_ready,
	output bffa_pkg::op_t              push_op
);
	import bffa_pkg::*;

	logic             valid_s1;
	op_t              op_s1;
	op_t              op_c;
	logic [CNT_W-1:0] lim;
	logic [CNT_W-1:0] num_m1;

	assign lim    = (entries_in_use > LIMIT_MAX) ? LIMIT_MAX : entries_in_use;
	assign num_m1 = req.entry_number - CNT_W'(1);

	always_comb begin
		op_c.lim      = lim;
		op_c.word_idx = num_m1[BIT_W +: ADDR_W];
		op_c.bit_idx  = num_m1[BIT_W-1:0];
		if (!req.cmd) begin
			op_c.kind = OP_ALLOC;
		end else if (req.entry_number == '0 || req.entry_number > lim) begin
			op_c.kind = OP_REJECT;
		end else begin
			op_c.kind = OP_FREE;
		end
	end

	assign req.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_op    = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1 <= op_c;
		end
	end

endmodule

>>> hdl/bffa_queue.sv
// Two-entry queue of classified operations between front and back end.
// Depends on bffa_pkg.
module bffa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  bffa_pkg::op_t push_op,
	output logic          pop_valid,
	input  logic          pop_ready,
	output bffa_pkg::op_t pop_op
);
	import bffa_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_QW = $clog2(DEPTH + 1);

	op_t               slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != CNT_QW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_op     = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_op;
		end
	end

endmodule

>>> hdl/bffa_back.sv
// Back end: bitmap memory, per-word full summary, first-fit search,
// read-modify-write and the response register. Depends on bffa_pkg, bffa_if.
module bffa_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pop_valid,
	output logic                       pop_ready,
	input  bffa_pkg::op_t              pop_op,
	bffa_rsp_if.source                 rsp,
	output logic [bffa_pkg::CNT_W-1:0] used_count
);
	import bffa_pkg::*;

	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	bk_state_t state_q, state_d;

	logic [WORD_W-1:0]      mem [WORD_CNT];
	logic [WORD_CNT-1:0]    row_vld_q;
	logic [WORD_CNT-1:0]    full_q;
	logic [CNT_W-1:0]       used_q;
	logic                   out_valid_q;

	op_t                    op_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [CHUNK_IDX_W-1:0] chunk_q;
	logic [WORD_W-1:0]      rd_s2;
	logic                   rd_vld_s2;
	status_t                status_q;
	logic [CNT_W-1:0]       granted_q;
	logic [CNT_W-1:0]       rsp_granted_q;
	status_t                rsp_status_q;
	logic [CNT_W-1:0]       rsp_free_q;

	logic [WORD_W-1:0]      free_vec;
	logic                   chunk_hit;
	logic [WORD_W-1:0]      word;
	logic [BIT_W-1:0]       alloc_bit;
	logic [ADDR_W+BIT_W-1:0] alloc_k;
	logic                   alloc_ok;
	logic                   free_ok;
	logic [WORD_W-1:0]      new_word;
	logic                   do_write;
	logic                   out_free;
	logic                   do_pop;
	logic [CNT_W-1:0]       free_cnt;

	// words of the current chunk that still have a clear bit
	assign free_vec  = ~full_q[{chunk_q, {BIT_W{1'b0}}} +: WORD_W];
	assign chunk_hit = |free_vec;

	assign word      = rd_vld_s2 ? rd_s2 : '0;
	assign alloc_bit = lowest_set(~word);
	assign alloc_k   = {addr_q, alloc_bit};
	assign alloc_ok  = {1'b0, alloc_k} < op_q.lim;
	assign free_ok   = word[op_q.bit_idx];

	always_comb begin
		if (op_q.kind == OP_ALLOC) begin
			new_word = word | (WORD_W'(1) << alloc_bit);
		end else begin
			new_word = word & ~(WORD_W'(1) << op_q.bit_idx);
		end
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign free_cnt = (op_q.lim > used_q) ? (op_q.lim - used_q) : '0;
	assign do_pop   = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		do_write  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					unique case (pop_op.kind)
						OP_ALLOC: state_d = BK_SCAN;
						OP_FREE:  state_d = BK_READ;
						default:  state_d = BK_FINISH;
					endcase
				end
			end
			BK_SCAN: begin
				if (chunk_hit) begin
					state_d = BK_READ;
				end else if (chunk_q == CHUNK_IDX_W'(CHUNK_CNT - 1)) begin
					state_d = BK_FINISH;
				end
			end
			BK_READ: begin
				state_d = BK_MODIFY;
			end
			BK_MODIFY: begin
				do_write = (op_q.kind == OP_ALLOC) ? alloc_ok : free_ok;
				state_d  = BK_FINISH;
			end
			BK_FINISH: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// control state: row valid bits, full summary, used count, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q   <= '0;
			full_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_write) begin
				row_vld_q[addr_q] <= 1'b1;
				full_q[addr_q]    <= &new_word;
				if (op_q.kind == OP_ALLOC) begin
					used_q <= used_q + CNT_W'(1);
				end else begin
					used_q <= used_q - CNT_W'(1);
				end
			end
			if (state_q == BK_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[addr_q] <= new_word;
		end
		if (state_q == BK_READ) begin
			rd_s2     <= mem[addr_q];
			rd_vld_s2 <= row_vld_q[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (do_pop) begin
					op_q      <= pop_op;
					addr_q    <= pop_op.word_idx;
					chunk_q   <= '0;
					granted_q <= '0;
					status_q  <= STATUS_BAD;
				end
			end
			BK_SCAN: begin
				if (chunk_hit) begin
					addr_q <= {chunk_q, lowest_set(free_vec)};
				end else begin
					chunk_q  <= chunk_q + CHUNK_IDX_W'(1);
					status_q <= STATUS_FULL;
				end
			end
			BK_MODIFY: begin
				if (op_q.kind == OP_ALLOC) begin
					if (alloc_ok) begin
						status_q  <= STATUS_OK;
						granted_q <= {1'b0, alloc_k} + CNT_W'(1);
					end else begin
						status_q  <= STATUS_FULL;
					end
				end else begin
					status_q <= free_ok ? STATUS_OK : STATUS_BAD;
				end
			end
			BK_FINISH: begin
				if (out_free) begin
					rsp_granted_q <= granted_q;
					rsp_status_q  <= status_q;
					rsp_free_q    <= free_cnt;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.granted_number = rsp_granted_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.free_entries   = rsp_free_q;
	assign used_count         = used_q;

endmodule

>>> hdl/bitmap_first_free_allocator.sv
// First-fit bitmap allocator over 8192 entries. An allocate request returns the
// lowest free entry below the configured limit as a 1-based number (0 and
// status 1 when none is free); a free request clears the given entry (status 2
// for zero, out-of-range or already free numbers). Every response carries the
// free count below the limit. Requests are classified in a front stage and
// queued two deep; the back end handles one at a time. An allocate scans the
// full-word summary one 32-word chunk at a time (eight chunks) until a word
// with a clear bit is found, then reads, writes and responds as a free does;
// a rejected free only responds. The front stage registers each request.
// Words carry reset-cleared valid bits, so the block takes requests straight
// after reset. entries_in_use may only be written while no request is
// outstanding. Depends on bffa_pkg, bffa_if, bffa_front, bffa_queue, bffa_back.
`include "assert_macros.svh"

module bitmap_first_free_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bffa_pkg::CNT_W-1:0] cfg_wr_data,
	bffa_req_if.sink                   req,
	bffa_rsp_if.source                 rsp
);
	import bffa_pkg::*;

	logic [CNT_W-1:0] entries_in_use_q;
	logic             fr_valid;
	logic             fr_ready;
	op_t              fr_op;
	logic             q_valid;
	logic             q_ready;
	op_t              q_op;
	logic [CNT_W-1:0] used_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= LIMIT_MAX;
		end else if (cfg_wr_en) begin
			entries_in_use_q <= cfg_wr_data;
		end
	end

	bffa_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.entries_in_use (entries_in_use_q),
		.req            (req),
		.push_valid     (fr_valid),
		.push_ready     (fr_ready),
		.push_op        (fr_op)
	);

	bffa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_op    (fr_op),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_op     (q_op)
	);

	bffa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_op     (q_op),
		.rsp        (rsp),
		.used_count (used_count)
	);

	`ASSERT_ALWAYS(a_used_bound, clk, arst_n, used_count <= LIMIT_MAX)
	`ASSERT_IMPLIES(a_grant_only_ok, clk, arst_n, rsp.valid && rsp.status != STATUS_OK, rsp.granted_number == '0)
	`ASSERT_IMPLIES(a_grant_in_limit, clk, arst_n, rsp.valid && rsp.granted_number != '0, rsp.granted_number <= entries_in_use_q)
	`ASSERT_NEXT(a_req_staged, clk, arst_n, req.valid && req.ready, fr_valid)

endmodule

>>> tb/allocation_checker.sv
`timescale 1ns / 100ps
// Request codes of the allocator testbench, and a checker that predicts every
// allocator response and compares it. Depends on bffa_pkg and bffa_if.
package alloc_cmd_pkg;
	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} alloc_cmd_t;
endpackage

module allocation_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bffa_pkg::CNT_W-1:0] cfg_wr_data,
	bffa_req_if                        req,
	bffa_rsp_if                        rsp,
	output int                         fault_count,
	output int                         awaiting,
	output int                         ok_count,
	output int                         full_count,
	output int                         bad_count
);
	import bffa_pkg::*;
	import alloc_cmd_pkg::*;

	typedef struct packed {
		logic [CNT_W-1:0] granted;
		status_t          status;
		logic [CNT_W-1:0] free_left;
	} response_t;

	bit               usage_map [MAX_ENTRIES];
	int               used_total;
	logic [CNT_W-1:0] limit_reg;
	response_t        expected_q [$];
	response_t        want;
	int               faults;
	int               oks, fulls, bads;

	// work out the response of one request and apply it to the bitmap
	function automatic response_t predict_response(input alloc_cmd_t op,
			input logic [CNT_W-1:0] num);
		response_t r;
		int        lim;
		int        avail;
		bit        found;
		lim = (limit_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(limit_reg);
		r.granted = '0;
		r.status = STATUS_OK;
		if (op == CMD_ALLOC) begin
			found = 1'b0;
			for (int k = 0; k < lim && !found; k++) begin
				if (!usage_map[k]) begin
					usage_map[k] = 1'b1;
					used_total++;
					r.granted = CNT_W'(k + 1);
					found = 1'b1;
				end
			end
			if (!found)
				r.status = STATUS_FULL;
		end else if (num == 0 || int'(num) > lim || !usage_map[int'(num) - 1]) begin
			r.status = STATUS_BAD;
		end else begin
			usage_map[int'(num) - 1] = 1'b0;
			if (used_total > 0)
				used_total--;
		end
		avail = (lim > used_total) ? lim - used_total : 0;
		r.free_left = CNT_W'(avail);
		return r;
	endfunction

	task automatic check_field(input string field, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field,
				exp_v, act_v);
			faults++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usage_map = '{default: 1'b0};
			used_total = 0;
			limit_reg = LIMIT_MAX;
			expected_q.delete();
			faults = 0;
			oks = 0;
			fulls = 0;
			bads = 0;
			fault_count <= 0;
			awaiting <= 0;
			ok_count <= 0;
			full_count <= 0;
			bad_count <= 0;
		end else begin
			// retire the response before queueing a request of the same edge
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: response with none expected, got %0d/%0d/%0d",
						$time, rsp.granted_number, rsp.status, rsp.free_entries);
					faults++;
				end else begin
					want = expected_q.pop_front();
					check_field("granted_number", want.granted, rsp.granted_number);
					check_field("status", want.status, rsp.status);
					check_field("free_entries", want.free_left, rsp.free_entries);
					case (want.status)
						STATUS_OK:   oks++;
						STATUS_FULL: fulls++;
						default:     bads++;
					endcase
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(predict_response(alloc_cmd_t'(req.cmd),
					req.entry_number));
			if (cfg_wr_en)
				limit_reg = cfg_wr_data;
			fault_count <= faults;
			awaiting <= expected_q.size();
			ok_count <= oks;
			full_count <= fulls;
			bad_count <= bads;
		end
	end

endmodule

>>> tb/bitmap_first_free_allocator_test.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the first-fit bitmap allocator.
// Depends on bffa_pkg, bffa_if, the allocator RTL and allocation_checker.
module bitmap_first_free_allocator_test;
	import bffa_pkg::*;
	import alloc_cmd_pkg::*;

	localparam int RUN_LIMIT_NS  = 5_000_000;
	localparam int SETTLE_CYCLES = 16;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;
	bit               no_idle;
	int               eff_limit;
	int               high_water;
	int               sent_count;
	int               limit_writes;
	int               fault_count;
	int               awaiting;
	int               ok_count;
	int               full_count;
	int               bad_count;

	bffa_req_if req_ch();
	bffa_rsp_if rsp_ch();

	bitmap_first_free_allocator uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	allocation_checker grant_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fault_count (fault_count),
		.awaiting    (awaiting),
		.ok_count    (ok_count),
		.full_count  (full_count),
		.bad_count   (bad_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#RUN_LIMIT_NS;
		$display("*** FAILED ***");
		$finish;
	end

	// response side: stall a random number of cycles before each response
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	task automatic send(input alloc_cmd_t op, input logic [CNT_W-1:0] num);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= 1'($urandom);
			req_ch.entry_number <= CNT_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= op;
		req_ch.entry_number <= num;
		do @(posedge clk); while (!req_ch.ready);
		sent_count++;
	endtask

	// hold off until every response is back and the back end has gone quiet
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [CNT_W-1:0] value);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		eff_limit = (value > MAX_ENTRIES) ? MAX_ENTRIES : int'(value);
		limit_writes++;
	endtask

	// set bits stay packed at the low end, so most frees aim below the high water
	function automatic logic [CNT_W-1:0] pick_free_number();
		int roll;
		int span;
		roll = $urandom_range(0, 99);
		span = (high_water < eff_limit) ? high_water : eff_limit;
		if (span < 1)
			span = 1;
		if (roll < 3)
			return '0;
		if (roll < 6)
			return CNT_W'($urandom);
		if (roll < 9)
			return CNT_W'(eff_limit + 1 + $urandom_range(0, 2));
		return CNT_W'($urandom_range(1, span));
	endfunction

	task automatic random_phase(input int count, input int alloc_pct);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < alloc_pct) begin
				if (high_water < eff_limit)
					high_water++;
				send(CMD_ALLOC, CNT_W'($urandom));
			end else begin
				send(CMD_FREE, pick_free_number());
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_ALLOC;
		req_ch.entry_number <= '0;
		no_idle = 1'b0;
		eff_limit = MAX_ENTRIES;
		high_water = 0;
		sent_count = 0;
		limit_writes = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first fit, refill of a hole, bad and already free numbers
		send(CMD_ALLOC, '1);
		send(CMD_ALLOC, '0);
		send(CMD_ALLOC, CNT_W'(5));
		send(CMD_FREE, CNT_W'(2));
		send(CMD_ALLOC, '0);
		send(CMD_FREE, '0);
		send(CMD_FREE, '1);
		send(CMD_FREE, CNT_W'(MAX_ENTRIES + 1));
		send(CMD_FREE, CNT_W'(5));
		send(CMD_FREE, CNT_W'(3));
		send(CMD_FREE, CNT_W'(3));
		// zero limit allows nothing
		set_limit('0);
		send(CMD_ALLOC, '0);
		send(CMD_FREE, CNT_W'(1));
		// full at a tiny limit
		set_limit(CNT_W'(2));
		send(CMD_ALLOC, '0);
		send(CMD_FREE, CNT_W'(2));
		send(CMD_ALLOC, '1);
		// entry above a lowered limit stays set and cannot be freed
		set_limit(CNT_W'(1));
		send(CMD_FREE, CNT_W'(2));
		send(CMD_ALLOC, '0);
		// limit above capacity acts as full capacity
		set_limit('1);
		send(CMD_FREE, CNT_W'(2));
		send(CMD_ALLOC, '0);
		high_water = 3;

		// fill past the first summary chunk, then churn
		set_limit(LIMIT_MAX);
		random_phase(1100, 98);
		random_phase(150, 55);
		set_limit(CNT_W'(1));
		random_phase(25, 50);
		set_limit(CNT_W'(8));
		random_phase(80, 50);
		set_limit(CNT_W'(33));
		random_phase(100, 55);
		set_limit('0);
		random_phase(10, 50);
		set_limit('1);
		random_phase(80, 40);
		repeat (2) begin
			set_limit(CNT_W'($urandom_range(2, 300)));
			random_phase(50, 55);
		end
		set_limit(LIMIT_MAX);
		random_phase(50, 50);
		settle();

		$display("Run covered %0d requests over %0d limit settings, entries up to %0d.",
			sent_count, limit_writes, high_water);
		$display("Responses seen: %0d ok, %0d full, %0d rejected.",
			ok_count, full_count, bad_count);
		if (fault_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/bffa_pkg.sv
hdl/bffa_if.sv
hdl/bffa_front.sv
hdl/bffa_queue.sv
hdl/bffa_back.sv
hdl/bitmap_first_free_allocator.sv
tb/allocation_checker.sv
tb/bitmap_first_free_allocator_test.sv
